>>> hw/rtl/record_exchange_sorter_unit_macros.svh
// ----------------------------------------------------------------------------
// record exchange sorter assertion macros
// shared helpers for the concurrent checks of the sorter unit
// ----------------------------------------------------------------------------
`ifndef RECORD_EXCHANGE_SORTER_UNIT_MACROS_SVH
`define RECORD_EXCHANGE_SORTER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RXS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rxs check failed");

// next-cycle implication, disabled during reset
`define RXS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rxs check failed");

`endif

>>> hw/rtl/rxs_pkg.sv
// ----------------------------------------------------------------------------
// rxs_pkg
// types and constants shared by the record exchange sorter modules
// ----------------------------------------------------------------------------
package rxs_pkg;

  localparam int MAX_RECORDS = 32;
  localparam int KEY_BITS    = 32;
  localparam int TAG_BITS    = 8;
  localparam int IDX_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } rec_t;

  // one classified input item on its way to the back end
  typedef struct packed {
    rec_t rec;
    logic last;
    logic drop;
  } qent_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               full;
    logic               empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    B_LOAD,
    B_JREAD,
    B_JWAIT,
    B_SCAN,
    B_ORD,
    B_OLOAD
  } bk_state_t;

endpackage

>>> hw/rtl/rxs_front.sv
// ----------------------------------------------------------------------------
// rxs_front
// accepts input records and marks those beyond store capacity as dropped
// ----------------------------------------------------------------------------
module rxs_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rxs_pkg::KEY_BITS-1:0] sort_key,
  input  logic [rxs_pkg::TAG_BITS-1:0] record_tag,
  input  logic                         last_record,
  input  rxs_pkg::q_stat_t             q_stat,
  output logic                         push,
  output rxs_pkg::qent_t               push_data
);

  logic [rxs_pkg::CNT_W-1:0] fill;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_data.rec.key = sort_key;
    push_data.rec.tag = record_tag;
    push_data.last    = last_record;
    push_data.drop    = (fill == rxs_pkg::CNT_W'(rxs_pkg::MAX_RECORDS));
  end

  // per-set fill count, mirrors the back end's store count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (push) begin
      if (last_record) begin
        fill <= '0;
      end else if (fill != rxs_pkg::CNT_W'(rxs_pkg::MAX_RECORDS)) begin
        fill <= fill + rxs_pkg::CNT_W'(1);
      end
    end
  end

endmodule

>>> hw/rtl/rxs_queue.sv
// ----------------------------------------------------------------------------
// rxs_queue
// short fifo between the front and back ends
// ----------------------------------------------------------------------------
module rxs_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rxs_pkg::qent_t   push_data,
  input  logic             pop,
  output rxs_pkg::qent_t   pop_data,
  output rxs_pkg::q_stat_t q_stat
);

  rxs_pkg::qent_t                 q_mem [rxs_pkg::Q_DEPTH];
  logic [rxs_pkg::Q_PTR_W-1:0]    wr_ptr;
  logic [rxs_pkg::Q_PTR_W-1:0]    rd_ptr;
  logic [rxs_pkg::Q_CNT_W-1:0]    count;

  assign pop_data     = q_mem[rd_ptr];
  assign q_stat.count = count;
  assign q_stat.full  = (count == rxs_pkg::Q_CNT_W'(rxs_pkg::Q_DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rxs_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + rxs_pkg::Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + rxs_pkg::Q_CNT_W'(1);
        2'b01:   count <= count - rxs_pkg::Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/rxs_back.sv
// ----------------------------------------------------------------------------
// rxs_back
// record store, exchange sort sequencer and output register
// ----------------------------------------------------------------------------
module rxs_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_data,
  input  rxs_pkg::q_stat_t             q_stat,
  output logic                         pop,
  input  rxs_pkg::qent_t               pop_data,
  output logic                         busy,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rxs_pkg::KEY_BITS-1:0] sorted_key,
  output logic [rxs_pkg::TAG_BITS-1:0] sorted_tag,
  output logic                         last_out,
  output logic                         records_dropped
);

  localparam int CW = rxs_pkg::CNT_W;
  localparam int IW = rxs_pkg::IDX_W;

  rxs_pkg::rec_t  store [rxs_pkg::MAX_RECORDS];
  rxs_pkg::rec_t  rd_data;
  rxs_pkg::rec_t  wr_data;
  logic [IW-1:0]  rd_addr;
  logic [IW-1:0]  wr_addr;
  logic           wr_en;

  rxs_pkg::bk_state_t state, state_next;
  logic [CW-1:0]  count, count_next;
  logic           overflow, overflow_next;
  logic           ascending;
  logic [CW-1:0]  j, j_next;
  logic [CW-1:0]  i, i_next;
  logic [CW-1:0]  k, k_next;
  rxs_pkg::rec_t  cur, cur_next;
  logic           pend_valid, pend_valid_next;
  logic [IW-1:0]  pend_idx, pend_idx_next;
  logic           out_valid_next;
  logic [rxs_pkg::KEY_BITS-1:0] sorted_key_next;
  logic [rxs_pkg::TAG_BITS-1:0] sorted_tag_next;
  logic           last_out_next;
  logic           records_dropped_next;
  logic [CW-1:0]  j_inc;
  logic [CW-1:0]  k_inc;

  assign j_inc = j + CW'(1);
  assign k_inc = k + CW'(1);
  assign busy  = (state != rxs_pkg::B_LOAD);

  // record store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_data <= store[rd_addr];
  end

  always_comb begin
    state_next           = state;
    count_next           = count;
    overflow_next        = overflow;
    j_next               = j;
    i_next               = i;
    k_next               = k;
    cur_next             = cur;
    pend_valid_next      = pend_valid;
    pend_idx_next        = pend_idx;
    out_valid_next       = out_valid && !out_ready;
    sorted_key_next      = sorted_key;
    sorted_tag_next      = sorted_tag;
    last_out_next        = last_out;
    records_dropped_next = records_dropped;
    pop                  = 1'b0;
    wr_en                = 1'b0;
    wr_addr              = j[IW-1:0];
    wr_data              = cur;
    rd_addr              = k[IW-1:0];

    case (state)
      rxs_pkg::B_LOAD: begin
        pop = !q_stat.empty;
        if (pop) begin
          if (pop_data.drop) begin
            overflow_next = 1'b1;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = count[IW-1:0];
            wr_data    = pop_data.rec;
            count_next = count + CW'(1);
          end
          if (pop_data.last) begin
            j_next     = '0;
            state_next = rxs_pkg::B_JREAD;
          end
        end
      end
      rxs_pkg::B_JREAD: begin
        rd_addr    = j[IW-1:0];
        state_next = rxs_pkg::B_JWAIT;
      end
      rxs_pkg::B_JWAIT: begin
        // cur holds the candidate for slot j during the inner pass; a swap replaces it
        cur_next        = rd_data;
        pend_valid_next = 1'b0;
        if (j == '0) begin
          i_next = CW'(1);
        end else if (ascending) begin
          i_next = '0;
        end else begin
          i_next = j_inc;
        end
        state_next = rxs_pkg::B_SCAN;
      end
      rxs_pkg::B_SCAN: begin
        // compare the record read last cycle and swap through cur
        if (pend_valid && (cur.key < rd_data.key)) begin
          wr_en    = 1'b1;
          wr_addr  = pend_idx;
          wr_data  = cur;
          cur_next = rd_data;
        end
        if (i < count) begin
          i_next = i + CW'(1);
          if (i != j) begin
            rd_addr         = i[IW-1:0];
            pend_valid_next = 1'b1;
            pend_idx_next   = i[IW-1:0];
          end else begin
            pend_valid_next = 1'b0;
          end
        end else begin
          pend_valid_next = 1'b0;
          if (!pend_valid) begin
            wr_en   = 1'b1;
            wr_addr = j[IW-1:0];
            wr_data = cur;
            j_next  = j_inc;
            if (j_inc == count) begin
              k_next     = '0;
              state_next = rxs_pkg::B_ORD;
            end else begin
              state_next = rxs_pkg::B_JREAD;
            end
          end
        end
      end
      rxs_pkg::B_ORD: begin
        rd_addr    = k[IW-1:0];
        state_next = rxs_pkg::B_OLOAD;
      end
      rxs_pkg::B_OLOAD: begin
        rd_addr = k[IW-1:0];
        if (!out_valid || out_ready) begin
          out_valid_next       = 1'b1;
          sorted_key_next      = rd_data.key;
          sorted_tag_next      = rd_data.tag;
          last_out_next        = (k_inc == count);
          records_dropped_next = overflow;
          k_next               = k_inc;
          if (k_inc == count) begin
            count_next    = '0;
            overflow_next = 1'b0;
            state_next    = rxs_pkg::B_LOAD;
          end else begin
            state_next = rxs_pkg::B_ORD;
          end
        end
      end
      default: begin
        state_next = rxs_pkg::B_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rxs_pkg::B_LOAD;
      count      <= '0;
      overflow   <= 1'b0;
      ascending  <= 1'b1;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      overflow   <= overflow_next;
      pend_valid <= pend_valid_next;
      out_valid  <= out_valid_next;
      if (cfg_we) begin
        ascending <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    j               <= j_next;
    i               <= i_next;
    k               <= k_next;
    cur             <= cur_next;
    pend_idx        <= pend_idx_next;
    sorted_key      <= sorted_key_next;
    sorted_tag      <= sorted_tag_next;
    last_out        <= last_out_next;
    records_dropped <= records_dropped_next;
  end

endmodule

>>> hw/rtl/record_exchange_sorter_unit.sv
// ----------------------------------------------------------------------------
// record_exchange_sorter_unit
// collects keyed records, exchange-sorts them in place and streams them out
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid/in_ready     sort_key, record_tag, last_record
//  out      out_valid/out_ready   sorted_key, sorted_tag, last_out, records_dropped
//  cfg      cfg_valid/cfg_ready   cfg_data (ascending)
//
// records load at one per cycle while the back end is in B_LOAD, via a four-entry
// queue into a 32-entry store. sorting does one compare per cycle, set by the single
// read port of the record store; output steps each record through B_ORD and B_OLOAD.
// input keeps filling the queue while the back end sorts or waits on out_ready.
// reset is synchronous; the store needs no clearing pass. cfg_ready is always high.
`include "record_exchange_sorter_unit_macros.svh"

module record_exchange_sorter_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rxs_pkg::KEY_BITS-1:0] sort_key,
  input  logic [rxs_pkg::TAG_BITS-1:0] record_tag,
  input  logic                         last_record,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rxs_pkg::KEY_BITS-1:0] sorted_key,
  output logic [rxs_pkg::TAG_BITS-1:0] sorted_tag,
  output logic                         last_out,
  output logic                         records_dropped,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data
);

  logic             q_push;
  logic             q_pop;
  rxs_pkg::qent_t   q_push_data;
  rxs_pkg::qent_t   q_pop_data;
  rxs_pkg::q_stat_t q_stat;
  logic             bk_busy;

  assign cfg_ready = 1'b1;

  rxs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sort_key   (sort_key),
    .record_tag (record_tag),
    .last_record(last_record),
    .q_stat     (q_stat),
    .push       (q_push),
    .push_data  (q_push_data)
  );

  rxs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_push_data),
    .pop      (q_pop),
    .pop_data (q_pop_data),
    .q_stat   (q_stat)
  );

  rxs_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .q_stat         (q_stat),
    .pop            (q_pop),
    .pop_data       (q_pop_data),
    .busy           (bk_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sorted_key     (sorted_key),
    .sorted_tag     (sorted_tag),
    .last_out       (last_out),
    .records_dropped(records_dropped)
  );

  // an accepted record is visible in the queue on the next cycle
  `RXS_ASSERT_NEXT(a_push_lands, clk, rst, in_valid && in_ready, q_stat.count != '0)
  // the back end never pops an empty queue
  `RXS_ASSERT_IMPL(a_pop_nonempty, clk, rst, q_pop, !q_stat.empty)
  // no records are taken from the queue while a sort or output pass runs
  `RXS_ASSERT_IMPL(a_no_pop_busy, clk, rst, bk_busy, !q_pop)

endmodule
